// ===== sv/oaht_pkg.sv =====
// ============================================================================
// oaht_pkg
// Shared types and constants for the open-addressing hash table.
// ============================================================================
package oaht_pkg;

    localparam int TableDepth = 1024;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int CntW       = IdxW + 1;
    localparam int KeyBytes   = 16;

    localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;

    localparam logic [1:0] OP_GET = 2'd0;
    localparam logic [1:0] OP_PUT = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;
    localparam logic [1:0] OP_CLR = 2'd3;

    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_LIVE  = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_INS  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic CFG_CAP = 1'b0;
    localparam logic CFG_WM  = 1'b1;

    // One stored slot entry (everything but the tag).
    typedef struct packed {
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [4:0]  key_len;
        logic [63:0] value;
    } entry_t;

    // Byte mask keeping the lowest n bytes of a 64-bit word.
    function automatic logic [63:0] byte_mask(input logic [4:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (5'(i) < n) m[8*i +: 8] = 8'hff;
        end
        return m;
    endfunction

endpackage

// ===== sv/oaht_hash.sv =====
// ============================================================================
// oaht_hash
// Byte-serial FNV-1 hash: one multiply and xor per cycle. The prime is
// 2^40 + 0x1b3, so h * prime is computed as (h << 40) + h * 0x1b3, which
// needs only a narrow constant multiply.
// ============================================================================
module oaht_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] key_lo,
    input  logic [63:0] key_hi,
    input  logic [4:0]  key_len,
    output logic        done,
    output logic [63:0] hash
);

    logic [63:0] h_reg, h_next;
    logic [4:0]  i_reg, i_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [7:0]  byte_sel;
    logic [63:0] prod;

    // Pick the current key byte.
    always_comb begin
        byte_sel = i_reg[3] ? key_hi[{i_reg[2:0], 3'b000} +: 8]
                            : key_lo[{i_reg[2:0], 3'b000} +: 8];
        prod = (h_reg << 40) + (h_reg * 64'h1b3);
    end

    // Step control.
    always_comb begin
        h_next    = h_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            h_next    = oaht_pkg::FNV_OFFSET;
            i_next    = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (i_reg >= key_len) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                h_next = prod ^ {56'd0, byte_sel};
                i_next = i_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
        h_reg <= h_next;
    end

    assign done = done_reg;
    assign hash = h_reg;

endmodule

// ===== sv/open_addressing_hash_table.sv =====
// ============================================================================
// open_addressing_hash_table
// Linear-probing key/value table with an FNV-1 home slot.
// ============================================================================
// After acceptance a request runs the byte-serial hash, then a memory read
// and a compare-and-decide step for each probed slot, then the write-back,
// the watermark compare and the output register. A clear sweeps the tag
// memory one slot a cycle over all 1024 slots, then runs the watermark
// compare and the output register. After reset the same sweep runs
// before the first request is taken. Configuration writes are taken only
// between requests. A finished result waits in the output register while
// the next request is accepted and processed; that request stalls in its
// output state until the waiting result has been taken.
module open_addressing_hash_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: opcode[1:0], key_lo[65:2], key_hi[129:66], key_len[134:130],
    // value_in[198:135], zero fill to 200 bits
    input  logic [199:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[1:0], value_out[65:2], slot_index[75:66],
    // above_watermark[76], zero fill to 80 bits
    output logic [79:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [6:0]   cfg_data
);

    localparam int IW = oaht_pkg::IdxW;
    localparam int CW = oaht_pkg::CntW;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_WR    = 4'd5;
    localparam logic [3:0] S_OUT   = 4'd6;
    localparam logic [3:0] S_CLR   = 4'd7;
    localparam logic [3:0] S_WM    = 4'd8;

    // Memories.
    logic [1:0]       tag_mem [oaht_pkg::TableDepth];
    oaht_pkg::entry_t ent_mem [oaht_pkg::TableDepth];
    logic [1:0]       tag_rd_reg;
    oaht_pkg::entry_t ent_rd_reg;

    logic [3:0]  state_reg, state_next;
    logic [3:0]  cap_log2_reg;
    logic [6:0]  wm_reg;
    logic [CW-1:0] used_reg, used_next;
    logic [1:0]  op_reg;
    logic [63:0] klo_reg, khi_reg, val_reg;
    logic [4:0]  klen_reg;
    logic [IW-1:0] addr_reg, addr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          found_reg, found_next;
    logic          free_reg, free_next;
    logic [IW-1:0] free_slot_reg, free_slot_next;
    logic [1:0]    free_tag_reg, free_tag_next;
    logic [1:0]    st_reg, st_next;
    logic [63:0]   vout_reg, vout_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic          wm_flag_reg, wm_flag_next;
    logic          mvalid_reg;
    logic [79:0]   mdata_reg;

    logic        hash_start, hash_done;
    logic [63:0] hash_val;
    logic [3:0]  lg_eff;
    logic [IW-1:0] cap_mask;
    logic [CW-1:0] cap;
    logic          tag_we, ent_we;
    logic [IW-1:0] wr_addr;
    logic [1:0]    tag_wdata;
    oaht_pkg::entry_t ent_wdata;
    logic          key_match;
    logic [4:0]    in_len;
    logic [17:0]   used_x100;
    logic [17:0]   wm_x_cap;
    logic          out_free;

    // Effective capacity.
    always_comb begin
        lg_eff = (cap_log2_reg < 4'd4) ? 4'd4 : cap_log2_reg;
        if (32'(lg_eff) > IW) lg_eff = 4'(IW);
        cap      = CW'(1) << lg_eff;
        cap_mask = IW'(cap - CW'(1));
    end

    assign in_len = (s_tdata[134:130] > 5'(oaht_pkg::KeyBytes))
                    ? 5'(oaht_pkg::KeyBytes) : s_tdata[134:130];

    oaht_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key_lo  (klo_reg),
        .key_hi  (khi_reg),
        .key_len (klen_reg),
        .done    (hash_done),
        .hash    (hash_val)
    );

    assign key_match = (tag_rd_reg == oaht_pkg::TAG_LIVE) &&
                       (ent_rd_reg.key_len == klen_reg) &&
                       (ent_rd_reg.key_lo == klo_reg) &&
                       (ent_rd_reg.key_hi == khi_reg);

    // Watermark compare: used*100/cap >= wm  <=>  used*100 >= wm*cap.
    assign used_x100 = 18'(used_reg) * 18'd100;
    assign wm_x_cap  = 18'(wm_reg) << lg_eff;

    // The output register can take a new result when it is empty or being read.
    assign out_free   = !mvalid_reg || m_tready;
    assign s_tready   = (state_reg == S_IDLE);
    assign cfg_ready  = (state_reg == S_IDLE);
    assign hash_start = s_tready && s_tvalid;

    // Main sequencer.
    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        free_tag_next  = free_tag_reg;
        st_next        = st_reg;
        vout_next      = vout_reg;
        slot_next      = slot_reg;
        wm_flag_next   = wm_flag_reg;
        tag_we         = 1'b0;
        ent_we         = 1'b0;
        wr_addr        = addr_reg;
        tag_wdata      = oaht_pkg::TAG_EMPTY;
        ent_wdata      = '{key_lo: klo_reg, key_hi: khi_reg, key_len: klen_reg,
                           value: val_reg};
        unique case (state_reg)
            S_INIT, S_CLR: begin
                tag_we = 1'b1;
                addr_next = addr_reg + IW'(1);
                if (addr_reg == IW'(oaht_pkg::TableDepth - 1)) begin
                    state_next = (state_reg == S_CLR) ? S_WM : S_IDLE;
                end
            end
            S_IDLE: begin
                if (hash_start) begin
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    cnt_next   = '0;
                    st_next    = oaht_pkg::ST_MISS;
                    vout_next  = '0;
                    slot_next  = '0;
                    addr_next  = '0;
                    used_next  = used_reg;
                    state_next = (s_tdata[1:0] == oaht_pkg::OP_CLR) ? S_CLR : S_HASH;
                    if (s_tdata[1:0] == oaht_pkg::OP_CLR) begin
                        st_next   = oaht_pkg::ST_HIT;
                        used_next = '0;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    addr_next  = IW'(hash_val) & cap_mask;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                cnt_next = cnt_reg + CW'(1);
                if (key_match) begin
                    found_next = 1'b1;
                    state_next = S_WR;
                end else begin
                    if (!free_reg && tag_rd_reg != oaht_pkg::TAG_LIVE) begin
                        free_next      = 1'b1;
                        free_slot_next = addr_reg;
                        free_tag_next  = tag_rd_reg;
                    end
                    if (tag_rd_reg == oaht_pkg::TAG_EMPTY ||
                        cnt_reg + CW'(1) == cap) begin
                        state_next = S_WR;
                    end else begin
                        addr_next  = (addr_reg + IW'(1)) & cap_mask;
                        state_next = S_RD;
                    end
                end
            end
            S_WR: begin
                state_next = S_WM;
                if (found_reg) begin
                    st_next   = oaht_pkg::ST_HIT;
                    slot_next = addr_reg;
                    if (op_reg == oaht_pkg::OP_GET) begin
                        vout_next = ent_rd_reg.value;
                    end else if (op_reg == oaht_pkg::OP_DEL) begin
                        tag_we    = 1'b1;
                        tag_wdata = oaht_pkg::TAG_TOMB;
                    end else begin
                        ent_we    = 1'b1;
                        ent_wdata = '{key_lo: ent_rd_reg.key_lo,
                                      key_hi: ent_rd_reg.key_hi,
                                      key_len: ent_rd_reg.key_len,
                                      value: val_reg};
                    end
                end else if (op_reg == oaht_pkg::OP_PUT) begin
                    if (free_reg) begin
                        st_next   = oaht_pkg::ST_INS;
                        slot_next = free_slot_reg;
                        wr_addr   = free_slot_reg;
                        tag_we    = 1'b1;
                        ent_we    = 1'b1;
                        tag_wdata = oaht_pkg::TAG_LIVE;
                        if (free_tag_reg == oaht_pkg::TAG_EMPTY) begin
                            used_next = used_reg + CW'(1);
                        end
                    end else begin
                        st_next = oaht_pkg::ST_FULL;
                    end
                end
            end
            S_WM: begin
                wm_flag_next = used_x100 >= wm_x_cap;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Memory ports: one write, one registered read.
    always_ff @(posedge aclk) begin
        if (tag_we) tag_mem[wr_addr] <= tag_wdata;
        if (ent_we) ent_mem[wr_addr] <= ent_wdata;
        tag_rd_reg <= tag_mem[addr_reg];
        ent_rd_reg <= ent_mem[addr_reg];
    end

    // Control and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            addr_reg     <= '0;
            used_reg     <= '0;
            cap_log2_reg <= 4'd4;
            wm_reg       <= 7'd70;
            mvalid_reg   <= 1'b0;
            cnt_reg      <= '0;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            used_reg  <= used_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            free_reg  <= free_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == oaht_pkg::CFG_CAP) cap_log2_reg <= cfg_data[3:0];
                else wm_reg <= cfg_data;
            end
            if (state_reg == S_OUT && out_free) mvalid_reg <= 1'b1;
            else if (m_tready) mvalid_reg <= 1'b0;
        end
        free_slot_reg <= free_slot_next;
        free_tag_reg  <= free_tag_next;
        st_reg        <= st_next;
        vout_reg      <= vout_next;
        slot_reg      <= slot_next;
        wm_flag_reg   <= wm_flag_next;
        if (hash_start) begin
            op_reg   <= s_tdata[1:0];
            klen_reg <= in_len;
            klo_reg  <= s_tdata[65:2] & oaht_pkg::byte_mask(in_len);
            khi_reg  <= (in_len > 5'd8) ?
                        (s_tdata[129:66] & oaht_pkg::byte_mask(in_len - 5'd8)) : 64'd0;
            val_reg  <= s_tdata[198:135];
        end
        if (state_reg == S_OUT && out_free) begin
            mdata_reg <= {3'd0, wm_flag_reg, 10'(slot_reg), vout_reg, st_reg};
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule
